FILE: src/cll_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and state type for the cursor linked list engine
// no dependencies

package cll_pkg;

   localparam int SLOTS_DEFAULT      = 16;
   localparam int VALUE_BITS_DEFAULT = 16;

   // fixed widths of the channel fields
   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 16;
   localparam int POSITION_W = 8;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 4;
   localparam int REMOVED_W  = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_HEAD    = 3'd0,
      ACT_TAIL    = 3'd1,
      ACT_AT_POS  = 3'd2,
      ACT_SORTED  = 3'd3,
      ACT_DEL_ONE = 3'd4,
      ACT_DEL_ALL = 3'd5,
      ACT_READ    = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC,
      S_START,
      S_WALK,
      S_LINK_NEW,
      S_LINK_PREV,
      S_DEL,
      S_UNLINK,
      S_DEL_END,
      S_READ,
      S_EMIT
   } state_type;

endpackage

FILE: src/cll_req_if.sv
`timescale 1ns / 1ps
// request channel of the cursor linked list engine: valid, ready and one operation
// depends on cll_pkg

interface cll_req_if import cll_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [ACTION_W-1:0]          action;
   logic signed [VALUE_W-1:0]    value;
   logic [POSITION_W-1:0]        position;

   modport source (output valid, action, value, position, input ready);
   modport sink   (input valid, action, value, position, output ready);
endinterface

FILE: src/cll_rsp_if.sv
`timescale 1ns / 1ps
// response channel of the cursor linked list engine: valid, ready and one result
// depends on cll_pkg

interface cll_rsp_if import cll_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic signed [VALUE_W-1:0]    element;
   logic [SLOT_W-1:0]            slot;
   logic [REMOVED_W-1:0]         removed_count;
   logic                         last;

   modport source (output valid, status, element, slot, removed_count, last, input ready);
   modport sink   (input valid, status, element, slot, removed_count, last, output ready);
endinterface

FILE: src/cursor_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// cursor linked list engine: one singly linked list with a free list in a slot pool
// depends on cll_pkg, cll_req_if, cll_rsp_if and cll_slot_store
//
//   channel    dir   beat                                      accepted when
//   req_chan   in    action, value, position                   valid && ready
//   rsp_chan   out   status, element, slot, removed_count, last valid && ready
//
// one item at a time; the list is walked one link per cycle through the link memory
// insert at head: allocate, then emit; full pool, delete or readout on an empty list: emit
// other inserts: allocate, start, walk one link at a time, link the new slot, link the previous slot, emit
// delete: walk the list, with an extra unlink step per match past the head, then finish and emit
// readout: one response per element; a result that waits in the output register stalls it
// reset is synchronous and sets an empty list with all slots on the free chain

module cursor_linked_list_engine_unit import cll_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   cll_req_if.sink   req_chan,
   cll_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(SLOTS + 1);
   localparam int AW = $clog2(SLOTS);
   localparam logic [IW-1:0] NIL = IW'(SLOTS);

   state_type state_ff, state_in;
   action_type action_ff, action_in;
   logic signed [VALUE_BITS-1:0] val_ff, val_in;
   logic [POSITION_W-1:0] pos_ff, pos_in;
   logic [IW-1:0] list_head_ff, list_head_in;
   logic [IW-1:0] free_head_ff, free_head_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] trav_ff, trav_in;
   logic [IW-1:0] cand_ff, cand_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic [IW-1:0] freed_ff, freed_in;
   logic [IW-1:0] removed_ff, removed_in;
   logic [POSITION_W-1:0] step_ff, step_in;

   status_type res_status_ff, res_status_in;
   logic signed [VALUE_W-1:0] res_element_ff, res_element_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [REMOVED_W-1:0] res_removed_ff, res_removed_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_element_ff, rsp_element_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [REMOVED_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic rsp_last_ff, rsp_last_in;

   // store ports
   logic [IW-1:0] val_raddr, link_raddr, val_waddr, link_waddr;
   logic [VALUE_BITS-1:0] val_rdata, val_wdata;
   logic [IW-1:0] link_rdata, link_wdata;
   logic val_we, link_we;

   logic req_fire, out_free, head_nil, free_nil;
   action_type req_act;
   logic signed [VALUE_BITS-1:0] req_val, rd_val;
   logic at_head, walk_adv, del_match, del_finish, unlink_finish, read_end;

   cll_slot_store #(
      .SLOTS      (SLOTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .val_raddr  (val_raddr[AW-1:0]),
      .val_rdata  (val_rdata),
      .val_we     (val_we),
      .val_waddr  (val_waddr[AW-1:0]),
      .val_wdata  (val_wdata),
      .link_raddr (link_raddr[AW-1:0]),
      .link_rdata (link_rdata),
      .link_we    (link_we),
      .link_waddr (link_waddr[AW-1:0]),
      .link_wdata (link_wdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_act  = action_type'(req_chan.action);
   assign req_val  = VALUE_BITS'(req_chan.value);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign head_nil = (list_head_ff == NIL);
   assign free_nil = (free_head_ff == NIL);
   assign rd_val   = $signed(val_rdata);

   assign at_head = (action_ff == ACT_HEAD) || head_nil ||
                    ((action_ff == ACT_AT_POS) && (pos_ff == '0)) ||
                    ((action_ff == ACT_SORTED) && (rd_val > val_ff));
   assign walk_adv = (action_ff == ACT_TAIL) ||
                     ((action_ff == ACT_AT_POS) &&
                      (({1'b0, step_ff} + (POSITION_W + 1)'(1)) < {1'b0, pos_ff})) ||
                     ((action_ff == ACT_SORTED) && (rd_val < val_ff));
   assign del_match     = (rd_val == val_ff);
   assign del_finish    = (action_ff == ACT_DEL_ONE) || (link_rdata == NIL);
   assign unlink_finish = (action_ff == ACT_DEL_ONE) || (cand_ff == NIL);
   assign read_end      = (link_rdata == NIL);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_act)
                  ACT_HEAD, ACT_TAIL, ACT_AT_POS, ACT_SORTED:
                     state_in = free_nil ? S_EMIT : S_ALLOC;
                  ACT_DEL_ONE, ACT_DEL_ALL:
                     state_in = head_nil ? S_EMIT : S_DEL;
                  ACT_READ:
                     state_in = head_nil ? S_EMIT : S_READ;
                  default:
                     state_in = S_IDLE;
               endcase
            end
         end
         S_ALLOC:     state_in = at_head ? S_EMIT : S_START;
         S_START:     state_in = (link_rdata == NIL) ? S_LINK_NEW : S_WALK;
         S_WALK: begin
            if (!walk_adv || (link_rdata == NIL)) begin
               state_in = S_LINK_NEW;
            end
         end
         S_LINK_NEW:  state_in = S_LINK_PREV;
         S_LINK_PREV: state_in = S_EMIT;
         S_DEL: begin
            if (del_match && (prev_ff != NIL)) begin
               state_in = S_UNLINK;
            end else if (del_match ? del_finish : read_end) begin
               state_in = S_DEL_END;
            end
         end
         S_UNLINK:    state_in = unlink_finish ? S_DEL_END : S_DEL;
         S_DEL_END:   state_in = S_EMIT;
         S_READ: begin
            if (out_free && read_end) begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath, memory control and outputs
   always_comb begin
      action_in      = action_ff;
      val_in         = val_ff;
      pos_in         = pos_ff;
      list_head_in   = list_head_ff;
      free_head_in   = free_head_ff;
      idx_in         = idx_ff;
      trav_in        = trav_ff;
      cand_in        = cand_ff;
      prev_in        = prev_ff;
      freed_in       = freed_ff;
      removed_in     = removed_ff;
      step_in        = step_ff;
      res_status_in  = res_status_ff;
      res_element_in = res_element_ff;
      res_slot_in    = res_slot_ff;
      res_removed_in = res_removed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_last_in    = rsp_last_ff;
      val_raddr      = list_head_ff;
      link_raddr     = list_head_ff;
      val_we         = 1'b0;
      val_waddr      = idx_ff;
      val_wdata      = val_ff;
      link_we        = 1'b0;
      link_waddr     = idx_ff;
      link_wdata     = cand_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               action_in      = req_act;
               val_in         = req_val;
               pos_in         = req_chan.position;
               trav_in        = list_head_ff;
               prev_in        = NIL;
               removed_in     = '0;
               res_removed_in = '0;
               res_slot_in    = '0;
               res_element_in = VALUE_W'(req_val);
               case (req_act)
                  ACT_HEAD, ACT_TAIL, ACT_AT_POS, ACT_SORTED: begin
                     link_raddr    = free_head_ff;
                     res_status_in = ST_FULL;
                  end
                  ACT_READ: begin
                     res_status_in  = ST_EMPTY;
                     res_element_in = '0;
                  end
                  default: begin
                     res_status_in = ST_EMPTY;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            idx_in       = free_head_ff;
            free_head_in = link_rdata;
            val_we       = 1'b1;
            val_waddr    = free_head_ff;
            res_status_in = ST_OK;
            res_slot_in   = SLOT_W'(free_head_ff);
            if (at_head) begin
               link_we      = 1'b1;
               link_waddr   = free_head_ff;
               link_wdata   = list_head_ff;
               list_head_in = free_head_ff;
            end
         end
         S_START: begin
            step_in    = '0;
            cand_in    = link_rdata;
            val_raddr  = link_rdata;
            link_raddr = link_rdata;
         end
         S_WALK: begin
            if (walk_adv) begin
               trav_in    = cand_ff;
               step_in    = step_ff + POSITION_W'(1);
               cand_in    = link_rdata;
               val_raddr  = link_rdata;
               link_raddr = link_rdata;
            end
         end
         S_LINK_NEW: begin
            // new slot takes over the successor of the insert point
            link_we    = 1'b1;
            link_waddr = idx_ff;
            link_wdata = cand_ff;
         end
         S_LINK_PREV: begin
            link_we    = 1'b1;
            link_waddr = trav_ff;
            link_wdata = idx_ff;
         end
         S_DEL: begin
            cand_in = link_rdata;
            if (del_match) begin
               // freed slot goes to the front of the free chain
               link_we      = 1'b1;
               link_waddr   = trav_ff;
               link_wdata   = free_head_ff;
               free_head_in = trav_ff;
               freed_in     = trav_ff;
               removed_in   = removed_ff + IW'(1);
               if (prev_ff == NIL) begin
                  list_head_in = link_rdata;
               end
            end else begin
               prev_in = trav_ff;
            end
            trav_in    = link_rdata;
            val_raddr  = link_rdata;
            link_raddr = link_rdata;
         end
         S_UNLINK: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = cand_ff;
            val_raddr  = cand_ff;
            link_raddr = cand_ff;
         end
         S_DEL_END: begin
            res_status_in  = (removed_ff == '0) ? ST_NOT_FOUND : ST_OK;
            res_slot_in    = (removed_ff == '0) ? '0 : SLOT_W'(freed_ff);
            res_removed_in = REMOVED_W'(removed_ff);
            res_element_in = VALUE_W'(val_ff);
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_element_in = VALUE_W'(rd_val);
               rsp_slot_in    = SLOT_W'(trav_ff);
               rsp_removed_in = '0;
               rsp_last_in    = read_end;
               trav_in        = link_rdata;
               val_raddr      = link_rdata;
               link_raddr     = link_rdata;
            end else begin
               // hold the read on the current element while the output stalls
               val_raddr  = trav_ff;
               link_raddr = trav_ff;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_element_in = res_element_ff;
               rsp_slot_in    = res_slot_ff;
               rsp_removed_in = res_removed_ff;
               rsp_last_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         list_head_ff <= NIL;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      idx_ff         <= idx_in;
      trav_ff        <= trav_in;
      cand_ff        <= cand_in;
      prev_ff        <= prev_in;
      freed_ff       <= freed_in;
      removed_ff     <= removed_in;
      step_ff        <= step_in;
      res_status_ff  <= res_status_in;
      res_element_ff <= res_element_in;
      res_slot_ff    <= res_slot_in;
      res_removed_ff <= res_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.element       = rsp_element_ff;
   assign rsp_chan.slot          = rsp_slot_ff;
   assign rsp_chan.removed_count = rsp_removed_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

FILE: src/cll_slot_store.sv
`timescale 1ns / 1ps
// slot pool storage: value memory and link memory, one write and one read port each
// depends on cll_pkg; link entries read as the reset free chain until written

module cll_slot_store import cll_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   localparam int IW        = $clog2(SLOTS + 1),
   localparam int AW        = $clog2(SLOTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [AW-1:0]         val_raddr,
   output logic [VALUE_BITS-1:0] val_rdata,
   input  logic                  val_we,
   input  logic [AW-1:0]         val_waddr,
   input  logic [VALUE_BITS-1:0] val_wdata,
   input  logic [AW-1:0]         link_raddr,
   output logic [IW-1:0]         link_rdata,
   input  logic                  link_we,
   input  logic [AW-1:0]         link_waddr,
   input  logic [IW-1:0]         link_wdata
);

   logic [VALUE_BITS-1:0] value_mem [SLOTS];
   logic [IW-1:0]         link_mem  [SLOTS];
   logic [SLOTS-1:0]      link_valid_ff;

   logic [VALUE_BITS-1:0] val_rdata_ff;
   logic [IW-1:0]         link_raw_ff;
   logic                  link_hit_ff;
   logic [AW-1:0]         link_addr_ff;

   // same-cycle write to the read address is forwarded
   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[val_waddr] <= val_wdata;
      end
      if (val_we && (val_waddr == val_raddr)) begin
         val_rdata_ff <= val_wdata;
      end else begin
         val_rdata_ff <= value_mem[val_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_addr_ff <= link_raddr;
      if (link_we && (link_waddr == link_raddr)) begin
         link_raw_ff <= link_wdata;
         link_hit_ff <= 1'b1;
      end else begin
         link_raw_ff <= link_mem[link_raddr];
         link_hit_ff <= link_valid_ff[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
      end else if (link_we) begin
         link_valid_ff[link_waddr] <= 1'b1;
      end
   end

   assign val_rdata  = val_rdata_ff;
   // unwritten entry: free chain i -> i+1, last slot -> null
   assign link_rdata = link_hit_ff ? link_raw_ff : (IW'(link_addr_ff) + IW'(1));

endmodule
